// ----- rtl/cc20_pkg.sv -----
package cc20_pkg;

  localparam int DoubleRounds = 10;
  localparam int RoundCountW = $clog2(2 * DoubleRounds + 1);

  localparam logic [31:0] Sigma0 = 32'h61707865;
  localparam logic [31:0] Sigma1 = 32'h3320646e;
  localparam logic [31:0] Sigma2 = 32'h79622d32;
  localparam logic [31:0] Sigma3 = 32'h6b206574;

  localparam logic [2:0] RegKey01 = 3'd0;
  localparam logic [2:0] RegKey23 = 3'd1;
  localparam logic [2:0] RegKey45 = 3'd2;
  localparam logic [2:0] RegKey67 = 3'd3;
  localparam logic [2:0] RegEnable = 3'd4;

  typedef logic [31:0] word_t;
  typedef word_t [15:0] block_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       bypass;
    logic       start;
    logic [15:0] conn;
    logic [31:0] seq;
  } item_t;

  function automatic word_t rotl(input word_t v, input int n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

  function automatic block_t quarter(input block_t w, input int a, input int b,
                                     input int c, input int d);
    block_t r;
    r = w;
    r[a] = r[a] + r[b]; r[d] = rotl(r[d] ^ r[a], 16);
    r[c] = r[c] + r[d]; r[b] = rotl(r[b] ^ r[c], 12);
    r[a] = r[a] + r[b]; r[d] = rotl(r[d] ^ r[a], 8);
    r[c] = r[c] + r[d]; r[b] = rotl(r[b] ^ r[c], 7);
    quarter = r;
  endfunction

endpackage

// ----- rtl/chacha20_packet_cipher.sv -----
// Byte-wide ChaCha20 packet cipher. A byte that starts a block (the first byte of a
// packet or every 64th byte after it) waits while the single round unit runs
// twenty rounds and the final add; other bytes and rejected bytes pass without
// waiting for the round unit while the output is not stalled. A two-entry queue
// decouples the input from the round engine, and the output is registered.
module chacha20_packet_cipher import cc20_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic [15:0] conn_ident,
  input  logic [31:0] seq_number,
  input  logic        first_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic        rejected
);

  logic [63:0] key01, key23, key45, key67;
  logic        enable;
  logic        q_valid;
  logic        q_pop;
  item_t       q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      key01 <= '0;
      key23 <= '0;
      key45 <= '0;
      key67 <= '0;
      enable <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        RegKey01: key01 <= cfg_data;
        RegKey23: key23 <= cfg_data;
        RegKey45: key45 <= cfg_data;
        RegKey67: key67 <= cfg_data;
        RegEnable: enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  cc20_front u_front (
    .clk, .rst, .cfg_enable(enable),
    .in_valid, .in_stall, .data_byte, .conn_ident, .seq_number, .first_byte, .last_byte,
    .q_valid, .q_pop, .q_item
  );

  cc20_back u_back (
    .clk, .rst, .key01, .key23, .key45, .key67,
    .q_valid, .q_pop, .q_item,
    .valid(out_valid), .stall(out_stall), .out_byte, .out_last, .rejected
  );

endmodule

// ----- rtl/cc20_front.sv -----
module cc20_front import cc20_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_enable,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic [15:0] conn_ident,
  input  logic [31:0] seq_number,
  input  logic        first_byte,
  input  logic        last_byte,
  output logic        q_valid,
  input  logic        q_pop,
  output item_t       q_item
);

  item_t      entries [2];
  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       push;
  item_t      incoming;

  assign in_stall = (count == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (count != 2'd0);
  assign q_item = entries[rd_ptr];

  always_comb begin
    incoming.data = data_byte;
    incoming.last = last_byte;
    incoming.bypass = !cfg_enable;
    incoming.start = first_byte;
    incoming.conn = conn_ident;
    incoming.seq = seq_number;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= incoming;
    end
    if (rst) begin
      count <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (q_pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue overfilled");
  assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst)
    (push && !q_pop) |=> count == $past(count) + 2'd1)
    else $error("queue count wrong");

endmodule

// ----- rtl/cc20_back.sv -----
module cc20_back import cc20_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [63:0] key01,
  input  logic [63:0] key23,
  input  logic [63:0] key45,
  input  logic [63:0] key67,
  input  logic        q_valid,
  output logic        q_pop,
  input  item_t       q_item,
  output logic        valid,
  input  logic        stall,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic        rejected
);

  typedef enum logic [1:0] {IDLE, ROUND, FINISH} state_t;

  state_t                 state;
  block_t                 init;
  block_t                 work;
  block_t                 keystream;
  logic [RoundCountW-1:0] round;
  logic [31:0]            block_count;
  logic [5:0]             position;
  logic [15:0]            conn;
  logic [31:0]            seq;
  logic                   out_free;
  logic                   need_block;
  logic [31:0]            cnt_use;
  logic [15:0]            conn_use;
  logic [31:0]            seq_use;
  logic [5:0]             pos_use;
  block_t                 init_next;
  block_t                 round_next;
  logic [7:0]             ks_byte;

  assign out_free = !valid || !stall;
  assign conn_use = q_item.start ? q_item.conn : conn;
  assign seq_use = q_item.start ? q_item.seq : seq;
  assign cnt_use = q_item.start ? 32'd1 : block_count;
  assign pos_use = q_item.start ? 6'd0 : position;
  assign need_block = (pos_use == 6'd0);
  assign ks_byte = keystream[pos_use[5:2]][8*pos_use[1:0] +: 8];
  assign q_pop = q_valid && out_free &&
                 (q_item.bypass || (state == IDLE && !need_block) || state == FINISH);

  always_comb begin
    init_next[0] = Sigma0;
    init_next[1] = Sigma1;
    init_next[2] = Sigma2;
    init_next[3] = Sigma3;
    init_next[4] = key01[31:0];
    init_next[5] = key01[63:32];
    init_next[6] = key23[31:0];
    init_next[7] = key23[63:32];
    init_next[8] = key45[31:0];
    init_next[9] = key45[63:32];
    init_next[10] = key67[31:0];
    init_next[11] = key67[63:32];
    init_next[12] = cnt_use;
    init_next[13] = {16'd0, conn_use};
    init_next[14] = seq_use;
    init_next[15] = seq_use ^ {16'd0, conn_use};
  end

  always_comb begin
    round_next = work;
    if (!round[0]) begin
      round_next = quarter(round_next, 0, 4, 8, 12);
      round_next = quarter(round_next, 1, 5, 9, 13);
      round_next = quarter(round_next, 2, 6, 10, 14);
      round_next = quarter(round_next, 3, 7, 11, 15);
    end else begin
      round_next = quarter(round_next, 0, 5, 10, 15);
      round_next = quarter(round_next, 1, 6, 11, 12);
      round_next = quarter(round_next, 2, 7, 8, 13);
      round_next = quarter(round_next, 3, 4, 9, 14);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      valid <= 1'b0;
      block_count <= 32'd1;
      position <= 6'd0;
      conn <= 16'd0;
      seq <= 32'd0;
      round <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (q_valid && !q_item.bypass && need_block) begin
            init <= init_next;
            work <= init_next;
            round <= '0;
            state <= ROUND;
          end
        end
        ROUND: begin
          work <= round_next;
          round <= round + 1'b1;
          if (round == RoundCountW'(2 * DoubleRounds - 1)) begin
            state <= FINISH;
          end
        end
        FINISH: begin
          if (out_free) begin
            for (int i = 0; i < 16; i++) begin
              keystream[i] <= work[i] + init[i];
            end
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
      if (q_pop) begin
        valid <= 1'b1;
        out_last <= q_item.last;
        rejected <= q_item.bypass;
        if (q_item.bypass) begin
          out_byte <= q_item.data;
        end else begin
          conn <= conn_use;
          seq <= seq_use;
          position <= pos_use + 6'd1;
          block_count <= (pos_use == 6'd63) ? cnt_use + 32'd1 : cnt_use;
          if (state == FINISH) begin
            out_byte <= q_item.data ^ 8'(work[0] + init[0]);
          end else begin
            out_byte <= q_item.data ^ ks_byte;
          end
        end
      end else if (out_free) begin
        valid <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (valid && stall) |=> valid && $stable(out_byte))
    else $error("held result changed");
  assert property (@(posedge clk) disable iff (rst)
    state == ROUND |-> round < RoundCountW'(2 * DoubleRounds))
    else $error("round count overrun");
  assert property (@(posedge clk) disable iff (rst)
    (q_pop && !q_item.bypass) |-> (state != ROUND))
    else $error("byte taken during block computation");

endmodule
